// ----- src/trs_pkg.sv -----
package trs_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_ENTRY_BITS  = 16;

    // width of the random word and of the bit counter of the remainder loop that reduces it
    localparam int WORD_BITS   = 32;
    localparam int DIV_CNT_W   = $clog2(WORD_BITS);

    // apb register map, one register at byte address 4*i
    localparam int APB_ADDR_BITS = 3;
    localparam logic REG_CYCLIC_MODE = 1'b0;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_RANGE      = 2'd2,
        ST_STEP_DONE  = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] entry_value;
        logic [7:0]  read_index;
        logic [31:0] random_word;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_value;
        logic [7:0]  picked_index;
        logic [7:0]  top_slot;
        logic        swapped;
        logic [8:0]  entry_count;
        status_t     status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_ENTRY,
        S_DIV,
        S_RD_PICK,
        S_RD_SLOT,
        S_WR_PICK,
        S_WR_SLOT,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic item_load;
        logic div_init;
        logic div_step;
        logic rd_index;
        logic rd_pick;
        logic rd_slot;
        logic wr_pick;
        logic wr_slot;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic range_err;
        logic step_done;
        logic div_last;
        logic pick_eq_slot;
    } dp_status_t;

endpackage

// ----- src/table_random_shuffle_top.sv -----
// Table shuffler: clear, load entries one per transaction, then shuffle in place
// with one random word per step transaction (Fisher-Yates by default, Sattolo
// when cyclic_mode is set over APB at address 0), or read an entry back.
// A transaction is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high and cannot be stalled,
// so the receiver must capture it in that cycle. After the accepting edge the
// sequencer dispatches: clear and load go straight to finish, a read first reads
// the entry unless the index is out of range, and a step that finds nothing left
// goes straight to finish. A shuffle step runs a restoring remainder loop that
// retires one bit of the 32-bit word per cycle, giving the word mod the number of
// candidate slots, then reads the picked entry; when it swaps it also reads the
// top slot and writes both back, two reads and two writes on the table memory.
// busy drops in the cycle done rises, so the next transaction can be accepted
// while the result shows. The table contents are not reset; only entries below
// the load count are ever read.
module table_random_shuffle_top
    import trs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ENTRY_BITS  = DEF_ENTRY_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // command channel
    input  logic                     start,
    output logic                     busy,
    input  in_item_t                 item,
    // result channel, one cycle strobe
    output logic                     done,
    output out_item_t                result,
    // apb configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    ctrl_cmd_t  ctl;
    dp_status_t dp_st;

    logic cyclic_mode_reg;
    logic cyclic_mode_next;
    logic reg_sel;

    // register index is the word address
    assign reg_sel = (paddr[APB_ADDR_BITS-1] == REG_CYCLIC_MODE);
    assign pready  = 1'b1;

    // write completes on the access cycle
    always_comb
    begin
        cyclic_mode_next = cyclic_mode_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            cyclic_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyclic_mode_reg <= 1'b0;
        end
        else
        begin
            cyclic_mode_reg <= cyclic_mode_next;
        end
    end

    // readback, unmapped addresses read zero
    assign prdata = reg_sel ? {31'b0, cyclic_mode_reg} : 32'b0;

    // sequencer
    trs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .dp_st (dp_st),
        .ctl   (ctl),
        .busy  (busy)
    );

    // table memory, remainder loop, counters and result register
    trs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_BITS  (ENTRY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cyclic_mode (cyclic_mode_reg),
        .ctl         (ctl),
        .dp_st       (dp_st),
        .result      (result),
        .done        (done)
    );

endmodule

// ----- src/trs_ctrl.sv -----
module trs_ctrl
    import trs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t dp_st,
    output ctrl_cmd_t  ctl,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (dp_st.cmd)
                    CMD_CLEAR, CMD_LOAD: state_next = S_FINISH;
                    CMD_READ:  state_next = dp_st.range_err ? S_FINISH : S_RD_ENTRY;
                    CMD_STEP:  state_next = dp_st.step_done ? S_FINISH : S_DIV;
                endcase
            end
            S_RD_ENTRY: state_next = S_FINISH;
            S_DIV:
            begin
                if (dp_st.div_last)
                begin
                    state_next = S_RD_PICK;
                end
            end
            S_RD_PICK:  state_next = dp_st.pick_eq_slot ? S_FINISH : S_RD_SLOT;
            S_RD_SLOT:  state_next = S_WR_PICK;
            S_WR_PICK:  state_next = S_WR_SLOT;
            S_WR_SLOT:  state_next = S_FINISH;
            S_FINISH:   state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy          = 1'b0;
                ctl.item_load = start;
            end
            S_DISPATCH: ctl.div_init = 1'b1;
            S_RD_ENTRY: ctl.rd_index = 1'b1;
            S_DIV:      ctl.div_step = 1'b1;
            S_RD_PICK:  ctl.rd_pick  = 1'b1;
            S_RD_SLOT:  ctl.rd_slot  = 1'b1;
            S_WR_PICK:  ctl.wr_pick  = 1'b1;
            S_WR_SLOT:  ctl.wr_slot  = 1'b1;
            S_FINISH:   ctl.finish   = 1'b1;
            default:    busy         = 1'b1;
        endcase
    end

endmodule

// ----- src/trs_dp.sv -----
module trs_dp
    import trs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ENTRY_BITS  = DEF_ENTRY_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   item,
    input  logic       cyclic_mode,
    input  ctrl_cmd_t  ctl,
    output dp_status_t dp_st,
    output out_item_t  result,
    output logic       done
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [ENTRY_BITS-1:0] mem [TABLE_DEPTH];

    in_item_t              item_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [IDX_W-1:0]      slot_reg;
    logic [IDX_W-1:0]      slot_next;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      rem_next;
    logic [WORD_BITS-1:0]  word_reg;
    logic [WORD_BITS-1:0]  word_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_next;
    logic [ENTRY_BITS-1:0] rd_data_reg;
    logic [ENTRY_BITS-1:0] tmp_reg;
    out_item_t             res_reg;
    out_item_t             res_next;
    logic                  done_reg;

    logic                  full;
    logic [CNT_W-1:0]      modulus;
    logic [CNT_W:0]        trial;
    logic [CNT_W:0]        diff;
    logic [IDX_W-1:0]      pick;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENTRY_BITS-1:0] wr_data;
    logic                  load_ok;
    logic                  step_ok;
    logic                  read_ok;

    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign pick    = rem_reg[IDX_W-1:0];
    assign modulus = cyclic_mode ? CNT_W'(slot_reg) : CNT_W'(slot_reg) + CNT_W'(1);

    assign dp_st.cmd          = item_reg.cmd;
    assign dp_st.range_err    = (32'(item_reg.read_index) >= 32'(count_reg));
    assign dp_st.step_done    = (slot_reg == '0);
    assign dp_st.div_last     = (div_cnt_reg == DIV_CNT_W'(WORD_BITS - 1));
    assign dp_st.pick_eq_slot = (pick == slot_reg);

    assign load_ok = (item_reg.cmd == CMD_LOAD) && !full;
    assign step_ok = (item_reg.cmd == CMD_STEP) && !dp_st.step_done;
    assign read_ok = (item_reg.cmd == CMD_READ) && !dp_st.range_err;

    // restoring remainder, one bit of the word per cycle
    assign trial = {rem_reg, word_reg[WORD_BITS-1]};
    assign diff  = trial - {1'b0, modulus};

    always_comb
    begin
        rem_next     = rem_reg;
        word_next    = word_reg;
        div_cnt_next = div_cnt_reg;
        if (ctl.div_init)
        begin
            rem_next     = '0;
            word_next    = item_reg.random_word;
            div_cnt_next = '0;
        end
        else if (ctl.div_step)
        begin
            rem_next     = (trial >= {1'b0, modulus}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            word_next    = {word_reg[WORD_BITS-2:0], 1'b0};
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // memory port selection
    always_comb
    begin
        rd_addr = slot_reg;
        if (ctl.rd_index)
        begin
            rd_addr = IDX_W'(item_reg.read_index);
        end
        else if (ctl.rd_pick)
        begin
            rd_addr = pick;
        end

        wr_en   = 1'b0;
        wr_addr = slot_reg;
        wr_data = tmp_reg;
        if (ctl.wr_pick)
        begin
            wr_en   = 1'b1;
            wr_addr = pick;
            wr_data = rd_data_reg;
        end
        else if (ctl.wr_slot)
        begin
            wr_en = 1'b1;
        end
        else if (ctl.finish && load_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = ENTRY_BITS'(item_reg.entry_value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // table bookkeeping and result
    always_comb
    begin
        count_next = count_reg;
        slot_next  = slot_reg;
        res_next   = '0;
        if (ctl.finish)
        begin
            unique case (item_reg.cmd)
                CMD_CLEAR:
                begin
                    count_next = '0;
                    slot_next  = '0;
                end
                CMD_LOAD:
                begin
                    if (full)
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        slot_next  = count_reg[IDX_W-1:0];
                    end
                end
                CMD_STEP:
                begin
                    if (!step_ok)
                    begin
                        res_next.status = ST_STEP_DONE;
                    end
                    else
                    begin
                        slot_next             = slot_reg - IDX_W'(1);
                        res_next.picked_index = 8'(pick);
                        res_next.top_slot     = 8'(slot_reg);
                        res_next.swapped      = !dp_st.pick_eq_slot;
                    end
                end
                CMD_READ:
                begin
                    if (read_ok)
                    begin
                        res_next.read_value = 16'(rd_data_reg);
                    end
                    else
                    begin
                        res_next.status = ST_RANGE;
                    end
                end
            endcase
            res_next.entry_count = 9'(count_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.item_load)
        begin
            item_reg <= item;
        end
        if (ctl.rd_slot)
        begin
            tmp_reg <= rd_data_reg;
        end
        if (ctl.finish)
        begin
            res_reg <= res_next;
        end
        rem_reg     <= rem_next;
        word_reg    <= word_next;
        div_cnt_reg <= div_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            slot_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            slot_reg  <= slot_next;
            done_reg  <= ctl.finish;
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

// ----- src/trs_checker.sv -----
module trs_checker
    import trs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input in_item_t                 item,
    input logic                     done,
    input out_item_t                result,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic [APB_ADDR_BITS-1:0] paddr,
    input logic [31:0]              pwdata,
    input logic [31:0]              prdata,
    input logic                     pready
);

    // a result only follows a transaction in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without transaction in flight");

    // an accepted transaction occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accept");

    // one result per transaction, never in two consecutive cycles
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // a step with nothing left reports no pick and no swap
    a_step_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_STEP_DONE) |->
            (result.picked_index == 8'd0 && !result.swapped && result.top_slot == 8'd0))
        else $error("finished step reported a pick");

    // an out of range read returns zero
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_RANGE) |-> (result.read_value == 16'd0))
        else $error("out of range read returned data");

endmodule

bind table_random_shuffle_top trs_checker u_checker (.*);

// ----- tb/testbench.sv -----
module testbench;
    import trs_pkg::*;

    // table size of the block as built with its default parameters, and test run sizes
    localparam int TABLE_SIZE    = DEF_TABLE_DEPTH;
    localparam int DIRECTED_ROWS = 25;
    localparam int ITEM_TARGET   = 1850;
    localparam int MODE_PHASES   = 4;
    localparam int GAP_PERCENT   = 7;
    localparam int TAIL_CYCLES   = 50;

    // byte address of the mode register on the apb port
    localparam logic [APB_ADDR_BITS-1:0] MODE_ADDR =
        APB_ADDR_BITS'(4 * int'(REG_CYCLIC_MODE));

    // one row of the directed table: the transaction, and a typed-in result
    // where it is obvious, otherwise the predictor supplies the result
    typedef struct packed {
        in_item_t  stim;
        logic      has_gold;
        out_item_t gold;
    } directed_row_t;

    localparam out_item_t NO_GOLD = '0;

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // empty table right after reset: step finds nothing, reads are out of range
        '{'{CMD_STEP,  16'h0000, 8'h00, 32'hFFFF_FFFF}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd0, ST_STEP_DONE}},
        '{'{CMD_READ,  16'h0000, 8'h00, 32'h0000_0000}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd0, ST_RANGE}},
        '{'{CMD_READ,  16'hFFFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd0, ST_RANGE}},
        // a single entry leaves nothing to shuffle
        '{'{CMD_LOAD,  16'hFFFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd1, ST_OK}},
        '{'{CMD_STEP,  16'h0000, 8'h00, 32'h0000_0000}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd1, ST_STEP_DONE}},
        '{'{CMD_LOAD,  16'h0000, 8'h00, 32'h0000_0000}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd2, ST_OK}},
        '{'{CMD_LOAD,  16'hA5A5, 8'h5A, 32'hA5A5_A5A5}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd3, ST_OK}},
        '{'{CMD_LOAD,  16'h5A5A, 8'hA5, 32'h5A5A_5A5A}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd4, ST_OK}},
        // read back both ends, then just past the end
        '{'{CMD_READ,  16'h0000, 8'h00, 32'h0000_0000}, 1'b1,
          '{16'hFFFF, 8'h00, 8'h00, 1'b0, 9'd4, ST_OK}},
        '{'{CMD_READ,  16'h0000, 8'h03, 32'h0000_0000}, 1'b1,
          '{16'h5A5A, 8'h00, 8'h00, 1'b0, 9'd4, ST_OK}},
        '{'{CMD_READ,  16'h0000, 8'h04, 32'h0000_0000}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd4, ST_RANGE}},
        // full walk: pick on the top slot, pick at zero, pick on the top again
        '{'{CMD_STEP,  16'h0000, 8'h00, 32'hFFFF_FFFF}, 1'b0, NO_GOLD},
        '{'{CMD_STEP,  16'hFFFF, 8'hFF, 32'h0000_0000}, 1'b0, NO_GOLD},
        '{'{CMD_STEP,  16'h0000, 8'h00, 32'h0000_0001}, 1'b0, NO_GOLD},
        '{'{CMD_STEP,  16'h0000, 8'h00, 32'h8000_0000}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd4, ST_STEP_DONE}},
        '{'{CMD_READ,  16'h0000, 8'h00, 32'h0000_0000}, 1'b0, NO_GOLD},
        '{'{CMD_READ,  16'h0000, 8'h01, 32'h0000_0000}, 1'b0, NO_GOLD},
        '{'{CMD_READ,  16'h0000, 8'h02, 32'h0000_0000}, 1'b0, NO_GOLD},
        '{'{CMD_READ,  16'h0000, 8'h03, 32'h0000_0000}, 1'b0, NO_GOLD},
        // a load restarts the walk from the new top entry
        '{'{CMD_LOAD,  16'h1234, 8'h00, 32'h0000_0000}, 1'b0, NO_GOLD},
        '{'{CMD_STEP,  16'h0000, 8'h00, 32'h0000_0005}, 1'b0, NO_GOLD},
        // clear with every unused field set
        '{'{CMD_CLEAR, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd0, ST_OK}},
        '{'{CMD_READ,  16'h0000, 8'h00, 32'h0000_0000}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd0, ST_RANGE}},
        '{'{CMD_STEP,  16'h0000, 8'h00, 32'h0000_0003}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd0, ST_STEP_DONE}},
        '{'{CMD_LOAD,  16'h0001, 8'h00, 32'h0000_0000}, 1'b1,
          '{16'h0000, 8'h00, 8'h00, 1'b0, 9'd1, ST_OK}}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    item;
    logic        done;
    out_item_t   result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // shadow copy of the table and its walk state, updated as transactions are taken
    logic [15:0] entry_tbl [TABLE_SIZE];
    logic [8:0]  held_count;
    logic [7:0]  walk_slot;
    logic        cyclic_mode_q;

    // results still owed by the block, oldest first
    out_item_t   expected_results [$];
    int unsigned mismatch_count;
    int unsigned items_sent;
    bit          no_gaps;

    table_random_shuffle_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial
    begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // work out what one transaction returns and update the shadow state
    task automatic predict_shuffle(input in_item_t it, output out_item_t res);
        logic [32:0] modulus;
        logic [7:0]  pick;
        logic [15:0] held;
        res = '0;
        res.status = ST_OK;
        case (it.cmd)
            CMD_CLEAR:
            begin
                // contents stay, but nothing below the count is left to read
                held_count = '0;
                walk_slot  = '0;
            end
            CMD_LOAD:
            begin
                if (held_count >= 9'(TABLE_SIZE))
                    res.status = ST_FULL;
                else
                begin
                    entry_tbl[held_count[7:0]] = it.entry_value;
                    held_count = held_count + 9'd1;
                    walk_slot  = 8'(held_count - 9'd1);
                end
            end
            CMD_STEP:
            begin
                if (walk_slot == 8'd0)
                    res.status = ST_STEP_DONE;
                else
                begin
                    // fisher-yates picks at or below the slot, sattolo strictly below
                    modulus = cyclic_mode_q ? 33'(walk_slot) : 33'(walk_slot) + 33'd1;
                    pick = 8'({1'b0, it.random_word} % modulus);
                    if (pick != walk_slot)
                    begin
                        held = entry_tbl[pick];
                        entry_tbl[pick] = entry_tbl[walk_slot];
                        entry_tbl[walk_slot] = held;
                        res.swapped = 1'b1;
                    end
                    res.picked_index = pick;
                    res.top_slot     = walk_slot;
                    walk_slot = walk_slot - 8'd1;
                end
            end
            CMD_READ:
            begin
                if (9'(it.read_index) >= held_count)
                    res.status = ST_RANGE;
                else
                    res.read_value = entry_tbl[it.read_index];
            end
        endcase
        res.entry_count = held_count;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // every result is flagged by done for one cycle only, so grab it at that edge
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no transaction pending, got %0h", $time, result);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("read_value",   32'(want.read_value),   32'(result.read_value));
                check_field("picked_index", 32'(want.picked_index), 32'(result.picked_index));
                check_field("top_slot",     32'(want.top_slot),     32'(result.top_slot));
                check_field("swapped",      32'(want.swapped),      32'(result.swapped));
                check_field("entry_count",  32'(want.entry_count),  32'(result.entry_count));
                check_field("status",       32'(want.status),       32'(result.status));
            end
        end
    end

    // present one transaction from the falling edge until the block takes it
    task automatic issue(input in_item_t it, input logic has_gold, input out_item_t gold);
        out_item_t predicted;
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // taken at this edge: shadow state moves on now
        predict_shuffle(it, predicted);
        expected_results.push_back(has_gold ? gold : predicted);
        items_sent++;
    endtask

    // random idle cycles on the command side
    task automatic maybe_gap();
        while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            @(negedge clk);
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_item(input in_item_t it);
        maybe_gap();
        issue(it, 1'b0, NO_GOLD);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // mode changes only with the block idle, then read the register back
    task automatic write_cyclic_mode(input logic mode);
        hold_until_drained();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= 32'(mode);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cyclic_mode_q = mode;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("cyclic_mode readback", 32'(mode), prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random word, leaning a little toward the ends of its range
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(0, 511));
            default: return $urandom;
        endcase
    endfunction

    // every field random, unused ones included
    function automatic in_item_t rand_item(input cmd_t c);
        in_item_t it;
        it.cmd         = c;
        it.entry_value = 16'($urandom);
        it.read_index  = 8'($urandom);
        it.random_word = rand_word();
        return it;
    endfunction

    // one clear / load / shuffle / read-back round with random content
    task automatic shuffle_round(input bit force_full);
        int       size;
        int       steps;
        int       pct;
        in_item_t it;
        pct = $urandom_range(0, 99);
        if (force_full || pct < 2)
            size = TABLE_SIZE;
        else if (pct < 15)
            size = $urandom_range(17, 64);
        else
            size = $urandom_range(0, 16);
        // occasionally keep the old contents and append to them
        if (force_full || $urandom_range(0, 9) != 0)
            send_item(rand_item(CMD_CLEAR));
        for (int n = 0; n < size; n++)
            send_item(rand_item(CMD_LOAD));
        // a full table turns further loads away
        if (held_count == 9'(TABLE_SIZE))
            repeat ($urandom_range(1, 3))
                send_item(rand_item(CMD_LOAD));
        // as many items as entries plus up to two, mostly steps, reads and noise mixed in
        steps = int'(held_count) + $urandom_range(0, 2);
        for (int n = 0; n < steps; n++)
        begin
            pct = $urandom_range(0, 99);
            if (pct < 72)
                it = rand_item(CMD_STEP);
            else if (pct < 94)
            begin
                it = rand_item(CMD_READ);
                if (held_count != 0 && $urandom_range(0, 1) == 1)
                    it.read_index = 8'($urandom_range(0, int'(held_count) - 1));
            end
            else
                it = rand_item(cmd_t'($urandom_range(0, 3)));
            send_item(it);
        end
        // read back up to 16 entries of the permuted table, in order when it holds no more than 16
        for (int n = 0; n < 16 && n < int'(held_count); n++)
        begin
            it = rand_item(CMD_READ);
            it.read_index = (held_count <= 9'd16) ? 8'(n)
                                                  : 8'($urandom_range(0, int'(held_count) - 1));
            send_item(it);
        end
    endtask

    initial
    begin
        // everything known from time zero, reset held low and then released on a falling edge
        rst_n   = 1'b0;
        start   = 1'b0;
        item    = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        held_count     = '0;
        walk_slot      = '0;
        cyclic_mode_q  = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        no_gaps        = 1'b0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows in the reset mode (fisher-yates)
        for (int n = 0; n < DIRECTED_ROWS; n++)
        begin
            maybe_gap();
            issue(DIRECTED[n].stim, DIRECTED[n].has_gold, DIRECTED[n].gold);
        end

        // random rounds, alternating modes; phase two runs without idle cycles
        for (int phase = 0; phase < MODE_PHASES; phase++)
        begin
            write_cyclic_mode(phase % 2 == 0);
            no_gaps = (phase == 2);
            // the first round of the first two phases fills the whole table
            shuffle_round(phase < 2);
            while (items_sent < DIRECTED_ROWS + (phase + 1) * (ITEM_TARGET / MODE_PHASES))
            begin
                // now and then let everything drain before going on
                if ($urandom_range(0, 99) < 3)
                    hold_until_drained();
                shuffle_round(1'b0);
            end
        end

        // drain and watch for stray results
        hold_until_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (expected_results.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
src/trs_pkg.sv
src/trs_ctrl.sv
src/trs_dp.sv
src/table_random_shuffle_top.sv
src/trs_checker.sv
tb/testbench.sv
